/* rtl/cpla_pkg.sv */
`timescale 1ns / 1ps
package cpla_pkg;

	localparam int ARC_STEPS  = 8;
	localparam int IDX_W      = $clog2(ARC_STEPS + 1);
	localparam int ROOT_STEPS = 32;
	localparam int DIV_STEPS  = 32;
	localparam int CNT_W      = $clog2(ROOT_STEPS);

	localparam logic [63:0] PIHALF_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30    = 64'd1073741824;
	localparam logic [63:0] HALF_Q30   = 64'd536870912;

	localparam logic [1:0] MK_LINEAR = 2'd0;
	localparam logic [1:0] MK_CCW    = 2'd1;
	localparam logic [1:0] MK_CW     = 2'd2;

	localparam logic [1:0] CFG_CUT_DEPTH = 2'd0;
	localparam logic [1:0] CFG_LEAD_IN   = 2'd1;
	localparam logic [1:0] CFG_LEAD_OUT  = 2'd2;

	typedef struct packed {
		logic signed [31:0] vertex_x;
		logic signed [31:0] vertex_y;
		logic               final_vertex;
	} vertex_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic [1:0]         motion_kind;
		logic               run_end;
	} point_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_INIT_VERTEX,
		OP_SET_PREV,
		OP_SETUP,
		OP_NORM,
		OP_SQX,
		OP_SQY,
		OP_ROOT_INIT,
		OP_ROOT_STEP,
		OP_DIVX_INIT,
		OP_DIVY_INIT,
		OP_DIV_STEP,
		OP_MUL_UY,
		OP_SET_CX,
		OP_SET_CY,
		OP_MUL_SIN,
		OP_MUL_COS,
		OP_EMIT_ARC,
		OP_EMIT_FIRST,
		OP_EMIT_CUR
	} op_t;

	typedef struct packed {
		op_t              op;
		logic             leaving;
		logic             last;
		logic [IDX_W-1:0] arc_idx;
	} cmd_t;

	typedef struct packed {
		logic fin;
		logic cur_eq_first;
		logic cur_eq_prev;
		logic rin_zero;
		logic rout_zero;
		logic norm_ok;
		logic out_free;
	} status_t;

	// One Taylor term step before its constant divisor.
	function automatic logic [63:0] taylor_next(input logic [63:0] term, input logic [63:0] x2);
		logic [63:0] res;
		res = (term * x2 + HALF_Q30) >> 30;
		return res;
	endfunction

	function automatic logic [30:0] clamp_q30(input logic signed [65:0] sum);
		logic [30:0] res;
		if (sum < 0)
			res = '0;
		else if (sum > $signed({2'b00, ONE_Q30}))
			res = ONE_Q30[30:0];
		else
			res = sum[30:0];
		return res;
	endfunction

	function automatic logic [30:0] sin_q30(input logic [63:0] t);
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [65:0] sum;
		x2   = (t * t + HALF_Q30) >> 30;
		term = t;
		sum  = $signed({2'b00, term});
		term = taylor_next(term, x2) / 64'd6;   sum = sum - $signed({2'b00, term});
		term = taylor_next(term, x2) / 64'd20;  sum = sum + $signed({2'b00, term});
		term = taylor_next(term, x2) / 64'd42;  sum = sum - $signed({2'b00, term});
		term = taylor_next(term, x2) / 64'd72;  sum = sum + $signed({2'b00, term});
		term = taylor_next(term, x2) / 64'd110; sum = sum - $signed({2'b00, term});
		term = taylor_next(term, x2) / 64'd156; sum = sum + $signed({2'b00, term});
		term = taylor_next(term, x2) / 64'd210; sum = sum - $signed({2'b00, term});
		return clamp_q30(sum);
	endfunction

	function automatic logic [30:0] cos_q30(input logic [63:0] t);
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [65:0] sum;
		x2   = (t * t + HALF_Q30) >> 30;
		term = ONE_Q30;
		sum  = $signed({2'b00, term});
		term = taylor_next(term, x2) / 64'd2;   sum = sum - $signed({2'b00, term});
		term = taylor_next(term, x2) / 64'd12;  sum = sum + $signed({2'b00, term});
		term = taylor_next(term, x2) / 64'd30;  sum = sum - $signed({2'b00, term});
		term = taylor_next(term, x2) / 64'd56;  sum = sum + $signed({2'b00, term});
		term = taylor_next(term, x2) / 64'd90;  sum = sum - $signed({2'b00, term});
		term = taylor_next(term, x2) / 64'd132; sum = sum + $signed({2'b00, term});
		term = taylor_next(term, x2) / 64'd182; sum = sum - $signed({2'b00, term});
		return clamp_q30(sum);
	endfunction

	function automatic logic [ARC_STEPS:0][30:0] sin_table();
		logic [ARC_STEPS:0][30:0] tab;
		for (int i = 0; i <= ARC_STEPS; i++)
			tab[i] = sin_q30((PIHALF_Q30 * 64'(i)) / 64'(ARC_STEPS));
		return tab;
	endfunction

	function automatic logic [ARC_STEPS:0][30:0] cos_table();
		logic [ARC_STEPS:0][30:0] tab;
		for (int i = 0; i <= ARC_STEPS; i++)
			tab[i] = cos_q30((PIHALF_Q30 * 64'(i)) / 64'(ARC_STEPS));
		return tab;
	endfunction

	localparam logic [ARC_STEPS:0][30:0] SIN_TAB = sin_table();
	localparam logic [ARC_STEPS:0][30:0] COS_TAB = cos_table();

endpackage

/* rtl/cpla_ctrl.sv */
`timescale 1ns / 1ps
module cpla_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  cpla_pkg::status_t status,
	output cpla_pkg::cmd_t    cmd
);
	import cpla_pkg::*;

	typedef enum logic [22:0] {
		S_IDLE   = 23'h000001,
		S_DECIDE = 23'h000002,
		S_SOLO   = 23'h000004,
		S_SETUP  = 23'h000008,
		S_NORM   = 23'h000010,
		S_SQX    = 23'h000020,
		S_SQY    = 23'h000040,
		S_SQINIT = 23'h000080,
		S_ROOT   = 23'h000100,
		S_DIVX0  = 23'h000200,
		S_DIVX   = 23'h000400,
		S_DIVY0  = 23'h000800,
		S_DIVY   = 23'h001000,
		S_MULUY  = 23'h002000,
		S_SETCX  = 23'h004000,
		S_SETCY  = 23'h008000,
		S_MULS   = 23'h010000,
		S_MULC   = 23'h020000,
		S_ARC    = 23'h040000,
		S_FIRST  = 23'h080000,
		S_CUR    = 23'h100000,
		S_CLOSE  = 23'h200000,
		S_FINISH = 23'h400000
	} state_t;

	localparam logic [1:0] SEEN_NONE = 2'd0;
	localparam logic [1:0] SEEN_ONE  = 2'd1;
	localparam logic [1:0] SEEN_MANY = 2'd2;

	state_t           state_q, state_d;
	logic [1:0]       seen_q, seen_d;
	logic             leaving_q, leaving_d;
	logic             close_q, close_d;
	logic             arc_out_q, arc_out_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [IDX_W-1:0] idx_q, idx_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			seen_q    <= SEEN_NONE;
			leaving_q <= 1'b0;
			close_q   <= 1'b0;
			arc_out_q <= 1'b0;
			cnt_q     <= '0;
			idx_q     <= '0;
		end else begin
			state_q   <= state_d;
			seen_q    <= seen_d;
			leaving_q <= leaving_d;
			close_q   <= close_d;
			arc_out_q <= arc_out_d;
			cnt_q     <= cnt_d;
			idx_q     <= idx_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d     = state_q;
		seen_d      = seen_q;
		leaving_d   = leaving_q;
		close_d     = close_q;
		arc_out_d   = arc_out_q;
		cnt_d       = cnt_q;
		idx_d       = idx_q;
		cmd.op      = OP_NONE;
		cmd.leaving = leaving_q;
		cmd.last    = 1'b0;
		cmd.arc_idx = idx_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (seen_q == SEEN_NONE) begin
					cmd.op = OP_INIT_VERTEX;
					if (status.fin) begin
						state_d = S_SOLO;
					end else begin
						seen_d  = SEEN_ONE;
						state_d = S_IDLE;
					end
				end else begin
					close_d   = status.fin && !status.cur_eq_first;
					arc_out_d = status.fin && !status.rout_zero && !status.cur_eq_prev;
					if (seen_q == SEEN_ONE) begin
						if (!status.rin_zero && !status.cur_eq_first) begin
							leaving_d = 1'b0;
							state_d   = S_SETUP;
						end else begin
							state_d = S_FIRST;
						end
					end else begin
						state_d = S_CUR;
					end
				end
			end
			S_SOLO: begin
				if (status.out_free) begin
					cmd.op   = OP_EMIT_CUR;
					cmd.last = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_SETUP: begin
				cmd.op  = OP_SETUP;
				state_d = S_NORM;
			end
			S_NORM: begin
				if (status.norm_ok)
					state_d = S_SQX;
				else
					cmd.op = OP_NORM;
			end
			S_SQX: begin
				cmd.op  = OP_SQX;
				state_d = S_SQY;
			end
			S_SQY: begin
				cmd.op  = OP_SQY;
				state_d = S_SQINIT;
			end
			S_SQINIT: begin
				cmd.op  = OP_ROOT_INIT;
				cnt_d   = '0;
				state_d = S_ROOT;
			end
			S_ROOT: begin
				cmd.op = OP_ROOT_STEP;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ROOT_STEPS - 1))
					state_d = S_DIVX0;
			end
			S_DIVX0: begin
				cmd.op  = OP_DIVX_INIT;
				cnt_d   = '0;
				state_d = S_DIVX;
			end
			S_DIVX: begin
				cmd.op = OP_DIV_STEP;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1))
					state_d = S_DIVY0;
			end
			S_DIVY0: begin
				cmd.op  = OP_DIVY_INIT;
				cnt_d   = '0;
				state_d = S_DIVY;
			end
			S_DIVY: begin
				cmd.op = OP_DIV_STEP;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1))
					state_d = S_MULUY;
			end
			S_MULUY: begin
				cmd.op  = OP_MUL_UY;
				state_d = S_SETCX;
			end
			S_SETCX: begin
				cmd.op  = OP_SET_CX;
				state_d = S_SETCY;
			end
			S_SETCY: begin
				cmd.op  = OP_SET_CY;
				idx_d   = '0;
				state_d = S_MULS;
			end
			S_MULS: begin
				cmd.op  = OP_MUL_SIN;
				state_d = S_MULC;
			end
			S_MULC: begin
				cmd.op  = OP_MUL_COS;
				state_d = S_ARC;
			end
			S_ARC: begin
				if (status.out_free) begin
					cmd.op   = OP_EMIT_ARC;
					cmd.last = leaving_q && (idx_q == IDX_W'(ARC_STEPS));
					if (idx_q == IDX_W'(ARC_STEPS)) begin
						state_d = leaving_q ? S_FINISH : S_FIRST;
					end else begin
						idx_d   = idx_q + 1'b1;
						state_d = S_MULS;
					end
				end
			end
			S_FIRST: begin
				if (status.out_free) begin
					cmd.op  = OP_EMIT_FIRST;
					state_d = S_CUR;
				end
			end
			S_CUR: begin
				if (status.out_free) begin
					cmd.op   = OP_EMIT_CUR;
					cmd.last = !close_q && !arc_out_q;
					if (close_q) begin
						state_d = S_CLOSE;
					end else if (arc_out_q) begin
						leaving_d = 1'b1;
						state_d   = S_SETUP;
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_CLOSE: begin
				if (status.out_free) begin
					cmd.op   = OP_EMIT_FIRST;
					cmd.last = !arc_out_q;
					if (arc_out_q) begin
						leaving_d = 1'b1;
						state_d   = S_SETUP;
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_FINISH: begin
				cmd.op  = OP_SET_PREV;
				seen_d  = status.fin ? SEEN_NONE : SEEN_MANY;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* rtl/cpla_datapath.sv */
`timescale 1ns / 1ps
module cpla_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	input  cpla_pkg::vertex_t in_data,
	input  cpla_pkg::cmd_t    cmd,
	output cpla_pkg::status_t status,
	input  logic              out_stall,
	output logic              out_valid,
	output cpla_pkg::point_t  out_data
);
	import cpla_pkg::*;

	logic signed [31:0] cut_depth_q;
	logic [30:0]        rin_q, rout_q;
	logic signed [31:0] cur_x_q, cur_y_q, first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic               fin_q;
	logic signed [31:0] px_q, py_q;
	logic [32:0]        ax_q, ay_q;
	logic               sx_q, sy_q;
	logic [30:0]        r_q;
	logic [62:0]        prod_q, v_q, root_q, bit_q;
	logic [31:0]        rem_q, dlow_q, quo_q, ux_q;
	logic signed [35:0] cx_q, cy_q;
	logic [33:0]        s_q;
	logic               out_valid_q;
	point_t             out_q;

	logic signed [31:0] base_x, base_y;
	logic signed [32:0] dx, dy;
	logic [32:0]        mx;
	logic [31:0]        mul_a, mul_b;
	logic [63:0]        mul_p;
	logic [63:0]        rsum;
	logic [33:0]        rnd;
	logic [63:0]        rb;
	logic               root_ge;
	logic [32:0]        trial;
	logic               div_ge;
	logic [30:0]        div_a;
	logic [61:0]        dvd;
	logic signed [35:0] cterm_x, cterm_y;
	logic signed [36:0] cx37, cy37, s37, c37, arc_x, arc_y;
	logic               out_free;

	function automatic logic [31:0] sat32(input logic signed [36:0] v);
		logic [31:0] res;
		if (v > 37'sd2147483647)
			res = 32'h7fffffff;
		else if (v < -37'sd2147483648)
			res = 32'h80000000;
		else
			res = v[31:0];
		return res;
	endfunction

	// Lead-in works from vertex 0 along the first edge, lead-out from the
	// final vertex along the last edge.
	assign base_x = cmd.leaving ? prev_x_q : first_x_q;
	assign base_y = cmd.leaving ? prev_y_q : first_y_q;
	assign dx     = $signed({cur_x_q[31], cur_x_q}) - $signed({base_x[31], base_x});
	assign dy     = $signed({cur_y_q[31], cur_y_q}) - $signed({base_y[31], base_y});
	assign mx     = (ax_q >= ay_q) ? ax_q : ay_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_SQX: begin
				mul_a = {1'b0, ax_q[30:0]};
				mul_b = {1'b0, ax_q[30:0]};
			end
			OP_SQY: begin
				mul_a = {1'b0, ay_q[30:0]};
				mul_b = {1'b0, ay_q[30:0]};
			end
			OP_MUL_UY: begin
				mul_a = {1'b0, r_q};
				mul_b = quo_q;
			end
			OP_SET_CX: begin
				mul_a = {1'b0, r_q};
				mul_b = ux_q;
			end
			OP_MUL_SIN: begin
				mul_a = {1'b0, r_q};
				mul_b = {1'b0, SIN_TAB[cmd.arc_idx]};
			end
			OP_MUL_COS: begin
				mul_a = {1'b0, r_q};
				mul_b = {1'b0, COS_TAB[cmd.arc_idx]};
			end
			default: begin
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign rsum  = {1'b0, prod_q} + HALF_Q30;
	assign rnd   = rsum[63:30];

	assign rb      = {1'b0, root_q} + {1'b0, bit_q};
	assign root_ge = ({1'b0, v_q} >= rb);

	assign trial  = {rem_q, dlow_q[31]};
	assign div_ge = (trial >= {1'b0, root_q[31:0]});
	assign div_a  = (cmd.op == OP_DIVY_INIT) ? ay_q[30:0] : ax_q[30:0];
	assign dvd    = {1'b0, div_a, 30'd0} + {31'd0, root_q[31:1]};

	// Center offsets: the sign of each product follows the rotated unit vector.
	assign cterm_x = (sy_q ^ cmd.leaving) ? -$signed({2'b00, rnd}) : $signed({2'b00, rnd});
	assign cterm_y = ~(sx_q ^ cmd.leaving) ? -$signed({2'b00, rnd}) : $signed({2'b00, rnd});

	assign cx37  = {cx_q[35], cx_q};
	assign cy37  = {cy_q[35], cy_q};
	assign s37   = $signed({3'b000, s_q});
	assign c37   = $signed({3'b000, rnd});
	assign arc_x = cmd.leaving ? (cx37 - c37) : (cx37 + s37);
	assign arc_y = cmd.leaving ? (cy37 + s37) : (cy37 - c37);

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cut_depth_q <= '0;
			rin_q       <= '0;
			rout_q      <= '0;
			first_x_q   <= '0;
			first_y_q   <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_CUT_DEPTH: cut_depth_q <= cfg_data;
					CFG_LEAD_IN:   rin_q       <= cfg_data[30:0];
					CFG_LEAD_OUT:  rout_q      <= cfg_data[30:0];
					default: begin
					end
				endcase
			end
			if (cmd.op == OP_LOAD)
				fin_q <= in_data.final_vertex;
			if (cmd.op == OP_INIT_VERTEX) begin
				first_x_q <= cur_x_q;
				first_y_q <= cur_y_q;
			end
			if (cmd.op == OP_INIT_VERTEX || cmd.op == OP_SET_PREV) begin
				prev_x_q <= cur_x_q;
				prev_y_q <= cur_y_q;
			end
			if (cmd.op == OP_EMIT_ARC || cmd.op == OP_EMIT_FIRST || cmd.op == OP_EMIT_CUR)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				cur_x_q <= in_data.vertex_x;
				cur_y_q <= in_data.vertex_y;
			end
			OP_SETUP: begin
				px_q <= cmd.leaving ? cur_x_q : first_x_q;
				py_q <= cmd.leaving ? cur_y_q : first_y_q;
				ax_q <= dx[32] ? 33'(-dx) : 33'(dx);
				ay_q <= dy[32] ? 33'(-dy) : 33'(dy);
				sx_q <= dx[32];
				sy_q <= dy[32];
				r_q  <= cmd.leaving ? rout_q : rin_q;
			end
			OP_NORM: begin
				if (mx[32] || mx[31]) begin
					ax_q <= ax_q >> 1;
					ay_q <= ay_q >> 1;
				end else begin
					ax_q <= ax_q << 1;
					ay_q <= ay_q << 1;
				end
			end
			OP_SQX: begin
				prod_q <= mul_p[62:0];
			end
			OP_SQY: begin
				v_q    <= prod_q;
				prod_q <= mul_p[62:0];
			end
			OP_ROOT_INIT: begin
				v_q    <= v_q + prod_q;
				root_q <= '0;
				bit_q  <= 63'd1 << 62;
			end
			OP_ROOT_STEP: begin
				if (root_ge) begin
					v_q    <= v_q - rb[62:0];
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			OP_DIVX_INIT: begin
				rem_q  <= {2'b00, dvd[61:32]};
				dlow_q <= dvd[31:0];
				quo_q  <= '0;
			end
			OP_DIVY_INIT: begin
				ux_q   <= quo_q;
				rem_q  <= {2'b00, dvd[61:32]};
				dlow_q <= dvd[31:0];
				quo_q  <= '0;
			end
			OP_DIV_STEP: begin
				rem_q  <= div_ge ? 32'(trial - {1'b0, root_q[31:0]}) : trial[31:0];
				dlow_q <= dlow_q << 1;
				quo_q  <= {quo_q[30:0], div_ge};
			end
			OP_MUL_UY: begin
				prod_q <= mul_p[62:0];
			end
			OP_SET_CX: begin
				cx_q   <= $signed({{4{px_q[31]}}, px_q}) + cterm_x;
				prod_q <= mul_p[62:0];
			end
			OP_SET_CY: begin
				cy_q <= $signed({{4{py_q[31]}}, py_q}) + cterm_y;
			end
			OP_MUL_SIN: begin
				prod_q <= mul_p[62:0];
			end
			OP_MUL_COS: begin
				s_q    <= rnd;
				prod_q <= mul_p[62:0];
			end
			OP_EMIT_ARC: begin
				out_q.point_x     <= sat32(arc_x);
				out_q.point_y     <= sat32(arc_y);
				out_q.point_z     <= cut_depth_q;
				out_q.motion_kind <= cmd.leaving ? MK_CW : MK_CCW;
				out_q.run_end     <= cmd.last;
			end
			OP_EMIT_FIRST: begin
				out_q.point_x     <= first_x_q;
				out_q.point_y     <= first_y_q;
				out_q.point_z     <= cut_depth_q;
				out_q.motion_kind <= MK_LINEAR;
				out_q.run_end     <= cmd.last;
			end
			OP_EMIT_CUR: begin
				out_q.point_x     <= cur_x_q;
				out_q.point_y     <= cur_y_q;
				out_q.point_z     <= cut_depth_q;
				out_q.motion_kind <= MK_LINEAR;
				out_q.run_end     <= cmd.last;
			end
			default: begin
			end
		endcase
	end

	assign status.fin          = fin_q;
	assign status.cur_eq_first = (cur_x_q == first_x_q) && (cur_y_q == first_y_q);
	assign status.cur_eq_prev  = (cur_x_q == prev_x_q) && (cur_y_q == prev_y_q);
	assign status.rin_zero     = (rin_q == '0);
	assign status.rout_zero    = (rout_q == '0);
	assign status.norm_ok      = (mx[32:30] == 3'b001);
	assign status.out_free     = out_free;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* rtl/contour_pass_with_lead_arcs_top.sv */
`timescale 1ns / 1ps
// Contour pass with lead-in and lead-out arcs.
// Input channel: one profile vertex per transfer (in_valid / in_stall), the
// final vertex of a profile flagged. Output channel: toolpath points
// (out_valid / out_stall), run_end set on the last point caused by a vertex.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 depth,
// 1 lead-in radius, 2 lead-out radius); the user is to write only while
// the block is idle, which the block itself does not enforce. One vertex is
// processed at a time; in_stall is high until its points are handed to the
// output register. Each arc runs edge normalization, 32 square-root steps,
// two 32-step divides for the unit vector, then a multiply-sine,
// multiply-cosine and emit state per arc point, the products sharing the
// single multiplier. A stalled receiver holds the output register and the
// sequencer waits before each point until it is taken. Reset clears the
// configuration registers, the profile state and the output valid.
module contour_pass_with_lead_arcs_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  cpla_pkg::vertex_t in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output cpla_pkg::point_t  out_data
);
	import cpla_pkg::*;

	cmd_t    cmd;
	status_t status;

	cpla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	cpla_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule
